// File: rtl/knob_to_clock_divider_settings_assert.svh
// Assertion macros for the knob to clock divider settings block.
`ifndef KNOB_TO_CLOCK_DIVIDER_SETTINGS_ASSERT_SVH
`define KNOB_TO_CLOCK_DIVIDER_SETTINGS_ASSERT_SVH

`ifndef SYNTH
`define KCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kcd assertion failed");
`define KCD_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("kcd assertion failed");
`else
`define KCD_ASSERT(lbl, prop)
`define KCD_ASSERT_NR(lbl, prop)
`endif

`endif

// File: rtl/kcd_pkg.sv
package kcd_pkg;

  localparam int unsigned SampleW           = 10;
  localparam int unsigned SumW              = 14;
  localparam int unsigned SamplesPerReading = 16;
  localparam int unsigned CountW            = $clog2(SamplesPerReading);
  localparam int unsigned PrescaleLimit     = 15;
  localparam int unsigned CodeW             = 4;
  localparam int unsigned CmpW              = 8;
  localparam int unsigned MinFreqW          = 16;
  localparam int unsigned FreqW             = 24;
  localparam int unsigned ClockW            = 25;
  localparam int unsigned DivW              = 25;
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned CfgDataW          = 25;

  localparam logic [SampleW-1:0]  PauseReset   = SampleW'(100);
  localparam logic [SampleW-1:0]  MaxThrReset  = SampleW'(1000);
  localparam logic [MinFreqW-1:0] MinFreqReset = MinFreqW'(2);
  localparam logic [FreqW-1:0]    MaxFreqReset = FreqW'(1000000);
  localparam logic [ClockW-1:0]   ClockReset   = ClockW'(8000000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAUSE    = 3'd0,
    CFG_MAX_THR  = 3'd1,
    CFG_MIN_FREQ = 3'd2,
    CFG_MAX_FREQ = 3'd3,
    CFG_CLOCK_HZ = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/kcd_div.sv
module kcd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kcd_pkg::div_req_t  req_i,
  output kcd_pkg::div_rsp_t  rsp_o
);
  import kcd_pkg::*;

  localparam int unsigned StepW = $clog2(DivW);

  logic [DivW-1:0]  quo_q, quo_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  dvs_q, dvs_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivW:0]    rem_sh;
  logic [DivW+1:0]  diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DivW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = ~diff[DivW+1];
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[DivW-2:0], ge};
      rem_d  = ge ? diff[DivW-1:0] : rem_sh[DivW-1:0];
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/knob_to_clock_divider_settings.sv
// Knob to clock divider settings.
// Input channel (in_valid_i/in_ready_o/adc_sample_i): one 10-bit knob sample
// per transfer. Samples are summed in groups of 16; a non-final sample leaves
// the block idle, so it is ready again in the next cycle.
// The sixteenth sample starts the settings computation: frequency selection,
// a restoring divider (clock_hz / (2 * freq)) and the hand-over of its
// quotient, prescale normalization (0 to 14 shift steps, one per cycle, then
// one closing check), and the load of the output register. The input stays
// not ready from that sample until the output register is loaded; a stopped
// clock skips the divider.
// Output channel (out_valid_o/out_ready_i): one result per 16 samples, held in
// a register until its transfer. While it waits, samples keep being taken;
// a finished computation waits in its last step until the register frees.
// Configuration (cfg_we_i/cfg_idx_i/cfg_wdata_i): the user must write it only
// while the block is idle (not enforced); unknown indexes are dropped.
// Reset clears the sample sum and count, drops any pending result and loads
// the default thresholds, frequencies and clock rate.
`include "knob_to_clock_divider_settings_assert.svh"

module knob_to_clock_divider_settings (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kcd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kcd_pkg::SampleW-1:0]   adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          clock_running_o,
  output logic [kcd_pkg::CodeW-1:0]     prescale_select_o,
  output logic [kcd_pkg::CmpW-1:0]      compare_value_o
);
  import kcd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_NORM = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  logic [SampleW-1:0]  pause_q, max_thr_q;
  logic [MinFreqW-1:0] min_freq_q;
  logic [FreqW-1:0]    max_freq_q;
  logic [ClockW-1:0]   clock_hz_q;

  state_e              state_q, state_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [SampleW-1:0]  avg_q, avg_d;
  logic [CodeW-1:0]    code_q, code_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic                stop_q, stop_d;
  logic                out_valid_q, out_valid_d;
  logic                running_q, running_d;
  logic [CodeW-1:0]    presc_q, presc_d;
  logic [CmpW-1:0]     cmp_q, cmp_d;

  logic                in_xfer;
  logic [SumW-1:0]     sum_next;
  logic [SampleW-1:0]  avg_diff;
  logic [MinFreqW:0]   freq_lin;
  logic [FreqW-1:0]    freq;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign sum_next   = sum_q + SumW'(adc_sample_i);

  always_comb begin
    avg_diff = avg_q - pause_q;
    freq_lin = {1'b0, min_freq_q} + (MinFreqW + 1)'(avg_diff >> 4);
    freq     = (avg_q > max_thr_q) ? max_freq_q : FreqW'(freq_lin);
    if (freq == '0) begin
      freq = FreqW'(1);
    end
  end

  always_comb begin
    state_d          = state_q;
    sum_d            = sum_q;
    cnt_d            = cnt_q;
    avg_d            = avg_q;
    code_d           = code_q;
    quo_d            = quo_q;
    stop_d           = stop_q;
    out_valid_d      = out_valid_q & ~out_ready_i;
    running_d        = running_q;
    presc_d          = presc_q;
    cmp_d            = cmp_q;
    div_req.start    = 1'b0;
    div_req.dividend = DivW'(clock_hz_q);
    div_req.divisor  = {freq, 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cnt_q == CountW'(SamplesPerReading - 1)) begin
            sum_d   = '0;
            cnt_d   = '0;
            avg_d   = SampleW'(sum_next >> CountW);
            state_d = ST_SEL;
          end else begin
            sum_d = sum_next;
            cnt_d = cnt_q + CountW'(1);
          end
        end
      end
      ST_SEL: begin
        code_d = CodeW'(1);
        if (avg_q < pause_q) begin
          stop_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          stop_d        = 1'b0;
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          quo_d   = div_rsp.quotient;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (quo_q > DivW'(2 ** CmpW - 1) && code_q < CodeW'(PrescaleLimit)) begin
          code_d = code_q + CodeW'(1);
          quo_d  = quo_q >> 1;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          running_d   = ~stop_q;
          presc_d     = stop_q ? '0 : code_q;
          if (stop_q || quo_q == '0) begin
            cmp_d = '0;
          end else begin
            cmp_d = quo_q[CmpW-1:0] - CmpW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  kcd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q    <= PauseReset;
      max_thr_q  <= MaxThrReset;
      min_freq_q <= MinFreqReset;
      max_freq_q <= MaxFreqReset;
      clock_hz_q <= ClockReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PAUSE:    pause_q    <= cfg_wdata_i[SampleW-1:0];
        CFG_MAX_THR:  max_thr_q  <= cfg_wdata_i[SampleW-1:0];
        CFG_MIN_FREQ: min_freq_q <= cfg_wdata_i[MinFreqW-1:0];
        CFG_MAX_FREQ: max_freq_q <= cfg_wdata_i[FreqW-1:0];
        CFG_CLOCK_HZ: clock_hz_q <= cfg_wdata_i[ClockW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      code_q      <= CodeW'(1);
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      code_q      <= code_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q     <= avg_d;
    quo_q     <= quo_d;
    running_q <= running_d;
    presc_q   <= presc_d;
    cmp_q     <= cmp_d;
  end

  assign out_valid_o       = out_valid_q;
  assign clock_running_o   = running_q;
  assign prescale_select_o = presc_q;
  assign compare_value_o   = cmp_q;

  `KCD_ASSERT(a_last_sample_starts,
      in_xfer && cnt_q == CountW'(SamplesPerReading - 1) |=> state_q == ST_SEL)
  `KCD_ASSERT(a_div_active, state_q == ST_DIV |-> div_rsp.busy || div_rsp.done)
  `KCD_ASSERT(a_code_range,
      state_q == ST_NORM |-> code_q >= CodeW'(1) && code_q <= CodeW'(PrescaleLimit))
  `KCD_ASSERT(a_stop_zero,
      out_valid_o && !clock_running_o |-> prescale_select_o == '0 && compare_value_o == '0)

endmodule
